>>> rtl/length_prefixed_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_defines
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// clocked check, off while reset is asserted
`define LPFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define LPFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int unsigned LEN_BYTES   = 4;   // bytes of an escaped length, 2..4
  localparam int unsigned EXT_CNT_W   = $clog2(LEN_BYTES);
  localparam int unsigned LEN_W       = 32;
  localparam logic [7:0]  ESCAPE_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_LEN = 3'b001,
    PH_EXT = 3'b010,
    PH_PAY = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        payload_byte;
    logic              frame_first;
    logic              frame_last;
    logic [LEN_W-1:0]  frame_length;
    logic              message_end;
  } out_word_t;

endpackage

>>> rtl/lpfd_decoder.sv
// ----------------------------------------------------------------------------
// lpfd_decoder
// Header and payload tracking: one input word per enable, zero or one result.
// ----------------------------------------------------------------------------
module lpfd_decoder import lpfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_word_t  word_i,
  output logic      res_valid_o,
  output out_word_t res_o
);

  localparam logic [EXT_CNT_W-1:0] ExtLast = EXT_CNT_W'(LEN_BYTES - 1);

  phase_e               phase_q, phase_d;
  logic [EXT_CNT_W-1:0] ext_cnt_q, ext_cnt_d;
  logic [LEN_W-1:0]     accum_q, accum_d;
  logic [LEN_W-1:0]     remaining_q, remaining_d;
  logic                 first_q, first_d;

  logic [7:0]       b;
  logic             eoi;
  logic [LEN_W-1:0] accum_shift;
  logic             pay_last;

  assign b           = word_i.data_byte;
  assign eoi         = word_i.end_of_input;
  assign accum_shift = {accum_q[LEN_W-9:0], b};
  assign pay_last    = (remaining_q <= LEN_W'(1));

  always_comb begin
    phase_d     = phase_q;
    ext_cnt_d   = ext_cnt_q;
    accum_d     = accum_q;
    remaining_d = remaining_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_PAYLOAD;

    if (en_i) begin
      case (phase_q)
        PH_EXT: begin
          accum_d = accum_shift;
          if (ext_cnt_q == ExtLast) begin
            ext_cnt_d = '0;
            if (accum_shift == '0) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_EMPTY;
              res_o.frame_last  = 1'b1;
              res_o.message_end = eoi;
              phase_d           = PH_LEN;
            end else if (eoi) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_TRUNC;
              res_o.message_end = 1'b1;
            end else begin
              remaining_d = accum_shift;
              first_d     = 1'b1;
              phase_d     = PH_PAY;
            end
          end else begin
            ext_cnt_d = ext_cnt_q + EXT_CNT_W'(1);
            if (eoi) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_TRUNC;
              res_o.message_end = 1'b1;
            end
          end
        end
        PH_PAY: begin
          res_valid_o = 1'b1;
          if (eoi && !pay_last) begin
            res_o.kind        = KIND_TRUNC;
            res_o.message_end = 1'b1;
          end else begin
            res_o.kind         = KIND_PAYLOAD;
            res_o.payload_byte = b;
            res_o.frame_first  = first_q;
            res_o.frame_last   = pay_last;
            res_o.frame_length = accum_q;
            res_o.message_end  = eoi;
          end
          first_d = 1'b0;
          if (pay_last) begin
            remaining_d = '0;
            phase_d     = PH_LEN;
            first_d     = 1'b1;
          end else begin
            remaining_d = remaining_q - LEN_W'(1);
          end
        end
        default: begin
          // expecting a length byte; the unused code behaves the same
          if (b == ESCAPE_BYTE) begin
            phase_d   = PH_EXT;
            ext_cnt_d = '0;
            accum_d   = '0;
            if (eoi) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_TRUNC;
              res_o.message_end = 1'b1;
            end
          end else if (b == 8'd0) begin
            phase_d           = PH_LEN;
            accum_d           = '0;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_EMPTY;
            res_o.frame_last  = 1'b1;
            res_o.message_end = eoi;
          end else begin
            accum_d = LEN_W'(b);
            if (eoi) begin
              res_valid_o       = 1'b1;
              res_o.kind        = KIND_TRUNC;
              res_o.message_end = 1'b1;
            end else begin
              remaining_d = LEN_W'(b);
              first_d     = 1'b1;
              phase_d     = PH_PAY;
            end
          end
        end
      endcase

      // every message end drops back to waiting for a length byte
      if (eoi) begin
        phase_d     = PH_LEN;
        ext_cnt_d   = '0;
        accum_d     = '0;
        remaining_d = '0;
        first_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      ext_cnt_q   <= '0;
      accum_q     <= '0;
      remaining_q <= '0;
      first_q     <= 1'b1;
    end else begin
      phase_q     <= phase_d;
      ext_cnt_q   <= ext_cnt_d;
      accum_q     <= accum_d;
      remaining_q <= remaining_d;
      first_q     <= first_d;
    end
  end

endmodule

>>> rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a length-prefixed multipart byte stream into framed payload words.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i / in_ready_o / in_data_i) takes one byte of
// the serialized message per word, with end_of_input on its final byte.
// The output channel (out_valid_o / out_ready_i / out_data_o) gives payload
// bytes with first/last marks, empty-frame words and truncation errors.
// Length bytes give no word unless they close a frame of length zero or
// meet an end mark early.
// A result word passes through the input register, then the result
// register, before it shows on out_valid_o.
// Throughput: one byte per cycle while the receiver does not stall, with a
// single decode step between the two registers.
// Reset returns the block to waiting for a length byte, with both
// registers empty.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more byte if it is empty; after that
// in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer import lpfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic      in_valid_q, in_valid_d;
  in_word_t  in_word_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  logic      advance;
  logic      res_valid;
  out_word_t res;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = advance ? (in_valid_q && res_valid) : out_valid_q;

  lpfd_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_valid_q && advance),
    .word_i      (in_word_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_data_i;
    end
    if (advance && in_valid_q && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

>>> rtl/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_checker import lpfd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  `LPFD_ASSERT_RST(a_idle_in_reset, !rst_ni |-> !out_valid_o, "result word shown in reset")

  `LPFD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result word changed")

  // non-payload words carry no byte, no first mark and no length
  `LPFD_ASSERT(a_nonpay_clean, out_valid_o && (out_data_o.kind != KIND_PAYLOAD) |-> (out_data_o.payload_byte == 8'd0) && !out_data_o.frame_first && (out_data_o.frame_length == '0), "non-payload word has payload fields set")

  // a truncation error always closes the message
  `LPFD_ASSERT(a_trunc_closes, out_valid_o && (out_data_o.kind == KIND_TRUNC) |-> out_data_o.message_end && !out_data_o.frame_last, "truncation error not closing message")

  // a new result needs a byte accepted through the input register before it
  `LPFD_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(in_fire, 2), "result word without an input byte")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);
